// ----- sv/vrt_pkg.sv -----
// Package for the voxel ray traversal block: FSM state, status codes, face
// codes and the saturated distance value. No dependencies.
`default_nettype none
package vrt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_AXIS,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_STEP,
    ST_EMIT
  } vrt_state_e;

  typedef enum logic [1:0] {
    STAT_PROBE = 2'd0,
    STAT_HIT   = 2'd1,
    STAT_MISS  = 2'd2
  } vrt_status_e;

  localparam logic [2:0] FACE_EAST   = 3'd0;
  localparam logic [2:0] FACE_WEST   = 3'd1;
  localparam logic [2:0] FACE_TOP    = 3'd2;
  localparam logic [2:0] FACE_BOTTOM = 3'd3;
  localparam logic [2:0] FACE_NORTH  = 3'd4;
  localparam logic [2:0] FACE_SOUTH  = 3'd5;

  localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ----- sv/voxel_ray_traversal.sv -----
// Top level of the voxel ray traversal (3D DDA) block.
// Depends on vrt_pkg.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+--------------------------------
//  in      | into      | in_valid_i / in_stall_o  | func, origin, dir, max_dist, opaque
//  out     | out of    | out_valid_o / out_stall_i| status, voxel, facing, distance
//
// A start word is accepted, its three direction components are squared, and each
// axis then either saturates its span for a zero component or runs a divide, a
// square root and a multiply on the bit-serial units shared by the three axes;
// then comes a step and the load of the output register.
// An answer word is decided, stepped unless it ends in a hit or a miss, and loaded into the output register.
// Reset clears the FSM, the ray state and the output valid.
// A finished result waits in the output register while out_stall_i is high;
// a new word is accepted meanwhile, and its result waits for the slot.
`default_nettype none
module voxel_ray_traversal
  import vrt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int CELL_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic signed [31:0] origin_z_i,
  input  wire logic signed [15:0] dir_x_i,
  input  wire logic signed [15:0] dir_y_i,
  input  wire logic signed [15:0] dir_z_i,
  input  wire logic        [31:0] max_dist_i,
  input  wire logic               voxel_opaque_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic             [1:0]  status_o,
  output logic signed      [15:0] voxel_x_o,
  output logic signed      [15:0] voxel_y_o,
  output logic signed      [15:0] voxel_z_o,
  output logic             [2:0]  facing_o,
  output logic             [31:0] distance_o
);

  // dividend is sum << 2F; quotient register at least 65 bits for the
  // saturation test against 2^64
  localparam int DW = 34 + 2 * FRAC_BITS;
  localparam int QW = (DW > 64) ? DW : 65;
  localparam int CW = $clog2(DW + 1);
  localparam int MW = FRAC_BITS + 33;

  vrt_state_e state_q, state_d;

  logic accept, load_out;

  // ray state
  logic                  active_q;
  logic [CELL_BITS-1:0]  cell_q [3];
  logic [31:0]           nb_q   [3];
  logic [31:0]           span_q [3];
  logic [2:0]            neg_q;
  logic [31:0]           trav_q;
  logic [31:0]           limit_q;
  logic [2:0]            face_q;
  vrt_status_e           stat_q;

  // start word operands
  logic signed [15:0]    dir_q  [3];
  logic [FRAC_BITS-1:0]  frac_q [3];
  logic [33:0]           sum_q;
  logic [1:0]            ax_q;
  logic [CW-1:0]         cnt_q;

  // serial divider
  logic [30:0]           d2_q;
  logic [DW-1:0]         dvd_q;
  logic [31:0]           rem_q;
  logic [QW-1:0]         quot_q;
  // serial square root
  logic [63:0]           sq_q;
  logic [33:0]           srem_q;
  logic [31:0]           root_q;
  // shift-add multiplier
  logic [FRAC_BITS:0]    fm_q;
  logic [MW-1:0]         acc_q;

  assign accept = in_valid_i && !in_stall_o;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!func_i) begin
            state_d = ST_SQUARE;
          end else if (!active_q || voxel_opaque_i || (trav_q > limit_q)) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_SQUARE: if (ax_q == 2'd2) state_d = ST_AXIS;
      ST_AXIS: begin
        if (dir_q[ax_q] != '0) state_d = ST_DIV;
        else if (ax_q == 2'd2) state_d = ST_STEP;
      end
      ST_DIV:  if (cnt_q == CW'(DW - 1)) state_d = ST_SQRT;
      ST_SQRT: if (cnt_q == CW'(31)) state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == CW'(FRAC_BITS + 1)) state_d = (ax_q == 2'd2) ? ST_STEP : ST_AXIS;
      end
      ST_STEP: state_d = ST_EMIT;
      ST_EMIT: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EMIT: load_out = !out_valid_o || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
        load_out   = 1'b0;
      end
    endcase
  end

  // ---------------- datapath helpers ----------------
  logic signed [31:0] sq_prod;
  assign sq_prod = dir_q[ax_q] * dir_q[ax_q];

  logic [32:0] div_r2;
  logic        div_ge;
  assign div_r2 = {rem_q, dvd_q[DW-1]};
  assign div_ge = div_r2 >= {2'b00, d2_q};

  logic [33:0] s_r2, s_trial;
  logic        s_ge;
  assign s_r2    = {srem_q[31:0], sq_q[63:62]};
  assign s_trial = {root_q, 2'b01};
  assign s_ge    = s_r2 >= s_trial;

  // root including the bit decided in the last iteration
  logic [31:0] span_new;
  assign span_new = (|quot_q[QW-1:64]) ? DIST_SAT : {root_q[30:0], s_ge};

  logic [MW-1:0] acc_next;
  assign acc_next = {acc_q[MW-2:0], 1'b0} + (fm_q[FRAC_BITS] ? MW'(span_q[ax_q]) : '0);

  logic [32:0] nb_prod;
  logic [31:0] nb_first;
  assign nb_prod  = acc_q[FRAC_BITS +: 33];
  assign nb_first = nb_prod[32] ? DIST_SAT : nb_prod[31:0];

  // axis choice: z wins ties, y beats x only when strictly smaller
  logic [1:0]  sel;
  logic [32:0] nb_add;
  always_comb begin
    if (nb_q[2] <= nb_q[0] && nb_q[2] <= nb_q[1]) sel = 2'd2;
    else if (nb_q[1] < nb_q[0])                   sel = 2'd1;
    else                                          sel = 2'd0;
    nb_add = {1'b0, nb_q[sel]} + {1'b0, span_q[sel]};
  end

  // per-axis start values from the input word
  logic [31:0] orig_in [3];
  logic [15:0] dir_in  [3];
  assign orig_in[0] = origin_x_i;
  assign orig_in[1] = origin_y_i;
  assign orig_in[2] = origin_z_i;
  assign dir_in[0]  = dir_x_i;
  assign dir_in[1]  = dir_y_i;
  assign dir_in[2]  = dir_z_i;

  logic [FRAC_BITS:0] f_init;
  always_comb begin
    if (dir_q[ax_q][15]) f_init = {1'b0, frac_q[ax_q]};
    else                 f_init = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac_q[ax_q]};
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cell_q[a] <= '0;
        nb_q[a]   <= '0;
        span_q[a] <= '0;
      end
      neg_q   <= '0;
      trav_q  <= '0;
      limit_q <= '0;
      face_q  <= FACE_EAST;
      stat_q  <= STAT_PROBE;
      ax_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!func_i) begin
              for (int a = 0; a < 3; a++) begin
                cell_q[a] <= CELL_BITS'($signed(orig_in[a]) >>> FRAC_BITS);
                neg_q[a]  <= dir_in[a][15];
              end
              limit_q  <= max_dist_i;
              trav_q   <= '0;
              active_q <= 1'b1;
              stat_q   <= STAT_PROBE;
              ax_q     <= '0;
            end else if (!active_q) begin
              stat_q <= STAT_MISS;
            end else if (voxel_opaque_i) begin
              active_q <= 1'b0;
              stat_q   <= STAT_HIT;
            end else if (trav_q > limit_q) begin
              active_q <= 1'b0;
              stat_q   <= STAT_MISS;
            end else begin
              stat_q <= STAT_PROBE;
            end
          end
        end
        ST_SQUARE: ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
        ST_AXIS: begin
          cnt_q <= '0;
          if (dir_q[ax_q] == '0) begin
            span_q[ax_q] <= DIST_SAT;
            nb_q[ax_q]   <= DIST_SAT;
            ax_q         <= ax_q + 2'd1;
          end
        end
        ST_DIV:  cnt_q <= (cnt_q == CW'(DW - 1)) ? '0 : cnt_q + CW'(1);
        ST_SQRT: begin
          cnt_q <= (cnt_q == CW'(31)) ? '0 : cnt_q + CW'(1);
          if (cnt_q == CW'(31)) span_q[ax_q] <= span_new;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(FRAC_BITS + 1)) begin
            nb_q[ax_q] <= nb_first;
            ax_q       <= ax_q + 2'd1;
          end
        end
        ST_STEP: begin
          if (neg_q[sel]) begin
            cell_q[sel] <= cell_q[sel] - CELL_BITS'(1);
            face_q      <= {sel, 1'b0};
          end else begin
            cell_q[sel] <= cell_q[sel] + CELL_BITS'(1);
            face_q      <= {sel, 1'b1};
          end
          trav_q    <= nb_q[sel];
          nb_q[sel] <= nb_add[32] ? DIST_SAT : nb_add[31:0];
        end
        default: ;
      endcase
    end
  end

  // operand and serial-unit registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !func_i) begin
          for (int a = 0; a < 3; a++) begin
            dir_q[a]  <= dir_in[a];
            frac_q[a] <= orig_in[a][FRAC_BITS-1:0];
          end
          sum_q <= '0;
        end
      end
      ST_SQUARE: sum_q <= sum_q + 34'(sq_prod[30:0]);
      ST_AXIS: begin
        d2_q   <= sq_prod[30:0];
        dvd_q  <= DW'({sum_q, {(2 * FRAC_BITS){1'b0}}});
        rem_q  <= '0;
        quot_q <= '0;
      end
      ST_DIV: begin
        dvd_q  <= {dvd_q[DW-2:0], 1'b0};
        rem_q  <= div_ge ? 32'(div_r2 - {2'b00, d2_q}) : div_r2[31:0];
        quot_q <= {quot_q[QW-2:0], div_ge};
        if (cnt_q == CW'(DW - 1)) begin
          sq_q   <= {quot_q[62:0], div_ge};
          srem_q <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        sq_q   <= {sq_q[61:0], 2'b00};
        srem_q <= s_ge ? s_r2 - s_trial : s_r2;
        root_q <= {root_q[30:0], s_ge};
        fm_q   <= f_init;
        acc_q  <= '0;
      end
      ST_MUL: begin
        if (cnt_q != CW'(FRAC_BITS + 1)) begin
          acc_q <= acc_next;
          fm_q  <= {fm_q[FRAC_BITS-1:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  logic [31:0] cell_ext [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell_ext[a] = 32'($signed(cell_q[a]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o   <= stat_q;
      voxel_x_o  <= cell_ext[0][15:0];
      voxel_y_o  <= cell_ext[1][15:0];
      voxel_z_o  <= cell_ext[2][15:0];
      facing_o   <= face_q;
      distance_o <= trav_q;
    end
  end

endmodule
`default_nettype wire

// ----- sv/vrt_checker.sv -----
// Port-level checks for voxel_ray_traversal, bound to the top level.
// Depends on vrt_pkg.
`default_nettype none
module vrt_checker
  import vrt_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [2:0]  facing_o
);

  // a word in flight keeps the input side stalled next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous word still in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_PROBE || status_o == STAT_HIT ||
                     status_o == STAT_MISS))
    else $error("bad status code");

  a_face_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (facing_o <= FACE_SOUTH))
    else $error("bad face code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result word changed");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .facing_o    (facing_o)
);
`default_nettype wire
